// ===== rtl/itoa_pkg.sv =====
// Package: types, constants and FSM state for the integer to decimal ASCII core.
package itoa_pkg;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned DIGITS   = 10;
	localparam int unsigned PIDX_W   = 4;
	localparam int unsigned BIT_W    = 2;
	localparam int unsigned POW_W    = 34;
	localparam int unsigned DIFF_W   = 35;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	localparam logic [PIDX_W-1:0] PIDX_TOP = PIDX_W'(DIGITS - 1);
	localparam logic [BIT_W-1:0]  BIT_TOP  = '1;

	typedef struct packed {
		logic               mode;
		logic [VALUE_W-1:0] value;
	} itoa_in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              last;
	} itoa_out_t;

	typedef enum logic {
		ST_IDLE,
		ST_CONV
	} itoa_state_t;

	function automatic logic [POW_W-1:0] pow10(input logic [PIDX_W-1:0] idx);
		logic [POW_W-1:0] p;
		case (idx)
			4'd0:    p = 34'd1;
			4'd1:    p = 34'd10;
			4'd2:    p = 34'd100;
			4'd3:    p = 34'd1000;
			4'd4:    p = 34'd10000;
			4'd5:    p = 34'd100000;
			4'd6:    p = 34'd1000000;
			4'd7:    p = 34'd10000000;
			4'd8:    p = 34'd100000000;
			4'd9:    p = 34'd1000000000;
			default: p = 34'd1;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/integer_to_decimal_ascii_core.sv =====
// Top level: 32-bit integer to decimal ASCII text, one character per beat.
//
//  channel   | ports                 | beat taken when
//  ----------+-----------------------+--------------------------
//  command   | start, busy, operand  | start && !busy
//  result    | strobe, result        | strobe (one cycle, no stall)
//
// Each item is the accept cycle, then 40 trial subtractions on one
// shared 35-bit subtractor (8, 4, 2 and 1 times each power of ten, ten powers).
// A digit leaves once its trial subtractions are done; a '-' leaves the cycle after accept.
// Leading zeros are dropped. Reset clears the sequencer and the strobe.
// The result side cannot stall; busy holds off new commands.
module integer_to_decimal_ascii_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  itoa_pkg::itoa_in_t   operand,
	output logic                 strobe,
	output itoa_pkg::itoa_out_t  result
);
	import itoa_pkg::*;

	itoa_state_t          state_q, state_d;
	logic [VALUE_W-1:0]   mag_q;
	logic [PIDX_W-1:0]    pidx_q;
	logic [BIT_W-1:0]     bit_q;
	logic [3:0]           digit_q;
	logic                 started_q;
	logic                 strobe_q;
	itoa_out_t            result_q;

	logic                 accept;
	logic                 neg;
	logic [DIFF_W-1:0]    shifted;
	logic [DIFF_W-1:0]    diff;
	logic                 fits;
	logic [3:0]           dig_next;
	logic                 digit_done;
	logic                 emit;

	assign accept   = start && !busy;
	assign neg      = operand.mode && operand.value[VALUE_W-1];
	assign shifted  = DIFF_W'(pow10(pidx_q)) << bit_q;
	assign diff     = {{(DIFF_W-VALUE_W){1'b0}}, mag_q} - shifted;
	assign fits     = !diff[DIFF_W-1];
	assign dig_next = digit_q | (4'(fits) << bit_q);
	assign digit_done = (state_q == ST_CONV) && (bit_q == '0);
	assign emit     = digit_done && (started_q || (dig_next != '0) || (pidx_q == '0));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_CONV;
			end
			ST_CONV: begin
				if (digit_done && pidx_q == '0)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_CONV: busy = 1'b1;
			default: busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			strobe_q  <= 1'b0;
			started_q <= 1'b0;
			pidx_q    <= '0;
			bit_q     <= '0;
			digit_q   <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= 1'b0;
			if (accept) begin
				strobe_q  <= neg;
				started_q <= 1'b0;
				pidx_q    <= PIDX_TOP;
				bit_q     <= BIT_TOP;
				digit_q   <= '0;
			end else if (state_q == ST_CONV) begin
				bit_q <= bit_q - 1'b1;
				if (digit_done) begin
					digit_q   <= '0;
					pidx_q    <= pidx_q - 1'b1;
					strobe_q  <= emit;
					started_q <= started_q || emit;
				end else begin
					digit_q <= dig_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q             <= neg ? (~operand.value + 1'b1) : operand.value;
			result_q.char_out <= CH_MINUS;
			result_q.last     <= 1'b0;
		end else if (state_q == ST_CONV) begin
			if (fits)
				mag_q <= diff[VALUE_W-1:0];
			if (digit_done) begin
				result_q.char_out <= CH_ZERO | {4'b0, dig_next};
				result_q.last     <= (pidx_q == '0);
			end
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ===== dv/integer_to_decimal_ascii_core_tb.sv =====
// Testbench: self-checking random and directed test of the decimal ASCII formatter core.
`timescale 1ns / 100ps

module integer_to_decimal_ascii_core_tb;

	import itoa_pkg::*;

	localparam int unsigned RANDOM_NUMBERS = 450;
	localparam int unsigned CYCLE_LIMIT    = 400000;
	localparam int unsigned DRAIN_CYCLES   = 60;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	itoa_in_t  operand = '0;
	logic      strobe;
	itoa_out_t result;

	itoa_in_t  numbers_to_send[$];
	itoa_out_t expected_chars[$];
	itoa_out_t next_char;
	int unsigned numbers_total;
	int unsigned numbers_sent;
	int unsigned char_errors;
	int unsigned cycles;
	int unsigned idle_pct;

	integer_to_decimal_ascii_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.operand (operand),
		.strobe  (strobe),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// expected text of one number, most significant digit first
	function automatic void spell_decimal(input itoa_in_t num);
		logic [VALUE_W-1:0] mag;
		logic [3:0]         digs[DIGITS];
		int                 ndig;
		itoa_out_t          ch;
		mag = num.value;
		ndig = 0;
		if (num.mode && num.value[VALUE_W-1]) begin
			mag = ~num.value + 1'b1;
			ch.char_out = CH_MINUS;
			ch.last = 1'b0;
			expected_chars.push_back(ch);
		end
		if (mag == '0) begin
			ch.char_out = CH_ZERO;
			ch.last = 1'b1;
			expected_chars.push_back(ch);
		end else begin
			while (mag != '0) begin
				digs[ndig] = 4'(mag % 10);
				mag = mag / 10;
				ndig++;
			end
			while (ndig > 0) begin
				ndig--;
				ch.char_out = CH_ZERO + CHAR_W'(digs[ndig]);
				ch.last = (ndig == 0);
				expected_chars.push_back(ch);
			end
		end
	endfunction

	task automatic queue_number(input logic mode, input logic [VALUE_W-1:0] value);
		itoa_in_t num;
		num.mode = mode;
		num.value = value;
		numbers_to_send.push_back(num);
	endtask

	// driver: sender idles 7% in the first third, 77% in the second, never in the last
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			operand <= '0;
		end else begin
			if (start && !busy) begin
				spell_decimal(operand);
			end
			if (!start || !busy) begin
				if (numbers_sent < numbers_total / 3)
					idle_pct = 7;
				else if (numbers_sent < 2 * numbers_total / 3)
					idle_pct = 77;
				else
					idle_pct = 0;
				if (numbers_to_send.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
					start <= 1'b1;
					operand <= numbers_to_send.pop_front();
					numbers_sent++;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected beat char=%h last=%b", $time,
					result.char_out, result.last);
				char_errors++;
			end else begin
				next_char = expected_chars.pop_front();
				if (result.char_out !== next_char.char_out) begin
					$display("%0t: char_out expected %h actual %h", $time,
						next_char.char_out, result.char_out);
					char_errors++;
				end
				if (result.last !== next_char.last) begin
					$display("%0t: last expected %b actual %b", $time,
						next_char.last, result.last);
					char_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] p;
		logic               m;
		numbers_sent = 0;
		char_errors = 0;
		cycles = 0;

		queue_number(1'b0, 32'd0);
		queue_number(1'b1, 32'd0);
		queue_number(1'b0, 32'd1);
		queue_number(1'b0, 32'd9);
		queue_number(1'b0, 32'd10);
		queue_number(1'b1, 32'd99);
		queue_number(1'b0, 32'd100);
		queue_number(1'b0, 32'd999999999);
		queue_number(1'b0, 32'd1000000000);
		queue_number(1'b0, 32'd4000000000);
		queue_number(1'b0, 32'hFFFF_FFFF);
		queue_number(1'b1, 32'hFFFF_FFFF);
		queue_number(1'b0, 32'h8000_0000);
		queue_number(1'b1, 32'h8000_0000);
		queue_number(1'b0, 32'h7FFF_FFFF);
		queue_number(1'b1, 32'h7FFF_FFFF);
		queue_number(1'b1, 32'h8000_0001);
		queue_number(1'b1, -32'sd9);
		queue_number(1'b1, -32'sd10);
		queue_number(1'b1, -32'sd1000000000);
		queue_number(1'b0, 32'hAAAA_AAAA);
		queue_number(1'b1, 32'h5555_5555);

		repeat (RANDOM_NUMBERS) begin
			m = $urandom_range(1, 0);
			case ($urandom_range(3, 0))
				0: v = $urandom;
				1: v = $urandom >> $urandom_range(31, 0);
				2: v = $urandom_range(20, 0);
				default: begin
					p = 1;
					repeat ($urandom_range(9, 0)) p = p * 10;
					v = p - 1 + $urandom_range(2, 0);
				end
			endcase
			if (m && $urandom_range(1, 0))
				v = -v;
			queue_number(m, v);
		end
		numbers_total = numbers_to_send.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (numbers_to_send.size() != 0 || start)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (char_errors == 0 && expected_chars.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/itoa_pkg.sv
rtl/integer_to_decimal_ascii_core.sv
dv/integer_to_decimal_ascii_core_tb.sv
